// ===== src/cftp_pkg.sv =====
// Shared widths, constants and pipeline payload types of the circumcircle block.
`default_nettype none
package cftp_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int IN_FRAC_BITS  = 4;
  localparam int OUT_FRAC_BITS = 8;
  localparam int OUT_W         = 32;
  localparam int THR_W         = 32;

  // front end: differences, products, e/f/det, numerators
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int EF_W    = PROD_W + 1;
  localparam int NUM_W   = DIFF_W + EF_W + 1;
  localparam int NMAG_W  = 3 * COORD_WIDTH + 1;
  localparam int ADET_W  = 2 * COORD_WIDTH + 2;

  // divider: quotient keeps one bit beyond the guard fraction bits
  localparam int GUARD     = OUT_FRAC_BITS + IN_FRAC_BITS;
  localparam int QS        = GUARD + 1;
  localparam int DIVD_W    = NMAG_W + QS;
  localparam int DEN_W     = ADET_W + IN_FRAC_BITS + 1;
  localparam int DIV_CELLS = DIVD_W;
  localparam int CXM_W     = DIVD_W - IN_FRAC_BITS;

  // radius: distance limit, squares and square root
  localparam int DLIM       = OUT_W + IN_FRAC_BITS;
  localparam int DIFF2_W    = DLIM + 4;
  localparam int HALF_W     = DLIM / 2;
  localparam int PP_W       = 2 * HALF_W;
  localparam int SQ_W       = 2 * DLIM;
  localparam int RADICAND_W = SQ_W + 2;
  localparam int ROOT_W     = RADICAND_W / 2;
  localparam int SREM_W     = ROOT_W + 1;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int RAD_W      = ROOT_W + 1 - IN_FRAC_BITS;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DIVD_W-1:0] num;
  } div_lane_t;

  typedef struct packed {
    logic   coll;
    logic   neg_x;
    logic   neg_y;
    coord_t x1;
    coord_t y1;
  } div_side_t;

  typedef struct packed {
    div_lane_t        lane_x;
    div_lane_t        lane_y;
    logic [DEN_W-1:0] den;
    div_side_t        side;
  } div_data_t;

  typedef struct packed {
    logic             coll;
    logic             sat_c;
    logic             big;
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
  } sqrt_side_t;

  typedef struct packed {
    logic [SREM_W-1:0]     rem;
    logic [ROOT_W-1:0]     root;
    logic [RADICAND_W-1:0] rad;
    sqrt_side_t            side;
  } sqrt_data_t;

endpackage
`default_nettype wire

// ===== src/cftp_ifs.sv =====
// Valid/ready channel interfaces: point triples in, circles out, threshold writes.
`default_nettype none
interface cftp_in_if;
  logic            valid;
  logic            ready;
  cftp_pkg::coord_t first_x;
  cftp_pkg::coord_t first_y;
  cftp_pkg::coord_t second_x;
  cftp_pkg::coord_t second_y;
  cftp_pkg::coord_t third_x;
  cftp_pkg::coord_t third_y;
  modport source(output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                 input ready);
  modport sink(input valid, first_x, first_y, second_x, second_y, third_x, third_y,
               output ready);
endinterface

interface cftp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cftp_pkg::OUT_W-1:0]   center_x;
  logic signed [cftp_pkg::OUT_W-1:0]   center_y;
  logic        [cftp_pkg::OUT_W-1:0]   radius;
  logic                                collinear;
  logic                                saturated;
  modport source(output valid, center_x, center_y, radius, collinear, saturated,
                 input ready);
  modport sink(input valid, center_x, center_y, radius, collinear, saturated,
               output ready);
endinterface

interface cftp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cftp_pkg::THR_W-1:0]    data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/cftp_front.sv =====
// Front pipeline: differences, determinant, collinear test and centre numerators.
`default_nettype none
module cftp_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire cftp_pkg::coord_t             x1,
  input  wire cftp_pkg::coord_t             y1,
  input  wire cftp_pkg::coord_t             x2,
  input  wire cftp_pkg::coord_t             y2,
  input  wire cftp_pkg::coord_t             x3,
  input  wire cftp_pkg::coord_t             y3,
  input  wire logic [cftp_pkg::THR_W-1:0]   thr,
  output logic                              out_valid,
  output cftp_pkg::div_data_t               out_data
);
  import cftp_pkg::*;

  logic [5:0] v_r;

  // stage 1
  logic signed [DIFF_W-1:0] a_r, b_r, c_r, d_r, sx2_r, sy2_r, sx3_r, sy3_r;
  coord_t x1_1_r, y1_1_r;
  // stage 2
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r, pd_r, pbc_r, pad_r;
  logic signed [DIFF_W-1:0] a2_r, b2_r, c2_r, d2_r;
  coord_t x1_2_r, y1_2_r;
  // stage 3
  logic signed [EF_W-1:0] e2_r, f2_r, det_r;
  logic signed [DIFF_W-1:0] a3_r, b3_r, c3_r, d3_r;
  coord_t x1_3_r, y1_3_r;
  // stage 4
  logic signed [NUM_W-1:0] m1_r, m2_r, m3_r, m4_r;
  logic [ADET_W-1:0] adet_r;
  logic coll4_r, negd_r;
  coord_t x1_4_r, y1_4_r;
  // stage 5
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic [ADET_W-1:0] adet5_r;
  logic coll5_r;
  coord_t x1_5_r, y1_5_r;
  // stage 6
  div_data_t out_r;

  logic [ADET_W-1:0] adet_nxt;
  logic [NMAG_W-1:0] nmx_nxt, nmy_nxt;

  always_comb begin
    adet_nxt = ADET_W'(det_r[EF_W-1] ? -det_r : det_r);
    nmx_nxt  = NMAG_W'(nx_r[NUM_W-1] ? -nx_r : nx_r);
    nmy_nxt  = NMAG_W'(ny_r[NUM_W-1] ? -ny_r : ny_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= DIFF_W'(x1) - DIFF_W'(x2);
      b_r    <= DIFF_W'(y1) - DIFF_W'(y2);
      c_r    <= DIFF_W'(x1) - DIFF_W'(x3);
      d_r    <= DIFF_W'(y1) - DIFF_W'(y3);
      sx2_r  <= DIFF_W'(x1) + DIFF_W'(x2);
      sy2_r  <= DIFF_W'(y1) + DIFF_W'(y2);
      sx3_r  <= DIFF_W'(x1) + DIFF_W'(x3);
      sy3_r  <= DIFF_W'(y1) + DIFF_W'(y3);
      x1_1_r <= x1;
      y1_1_r <= y1;

      pa_r   <= PROD_W'(a_r) * PROD_W'(sx2_r);
      pb_r   <= PROD_W'(b_r) * PROD_W'(sy2_r);
      pc_r   <= PROD_W'(c_r) * PROD_W'(sx3_r);
      pd_r   <= PROD_W'(d_r) * PROD_W'(sy3_r);
      pbc_r  <= PROD_W'(b_r) * PROD_W'(c_r);
      pad_r  <= PROD_W'(a_r) * PROD_W'(d_r);
      a2_r   <= a_r;
      b2_r   <= b_r;
      c2_r   <= c_r;
      d2_r   <= d_r;
      x1_2_r <= x1_1_r;
      y1_2_r <= y1_1_r;

      e2_r   <= EF_W'(pa_r) + EF_W'(pb_r);
      f2_r   <= EF_W'(pc_r) + EF_W'(pd_r);
      det_r  <= EF_W'(pbc_r) - EF_W'(pad_r);
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
      d3_r   <= d2_r;
      x1_3_r <= x1_2_r;
      y1_3_r <= y1_2_r;

      m1_r    <= NUM_W'(b3_r) * NUM_W'(f2_r);
      m2_r    <= NUM_W'(d3_r) * NUM_W'(e2_r);
      m3_r    <= NUM_W'(c3_r) * NUM_W'(e2_r);
      m4_r    <= NUM_W'(a3_r) * NUM_W'(f2_r);
      adet_r  <= adet_nxt;
      // a zero determinant is collinear whatever the threshold
      coll4_r <= (adet_nxt == '0) || ({{(ADET_W-THR_W){1'b0}}, thr} > adet_nxt);
      negd_r  <= det_r[EF_W-1];
      x1_4_r  <= x1_3_r;
      y1_4_r  <= y1_3_r;

      // fold the determinant sign into the numerators
      nx_r    <= negd_r ? m2_r - m1_r : m1_r - m2_r;
      ny_r    <= negd_r ? m4_r - m3_r : m3_r - m4_r;
      adet5_r <= adet_r;
      coll5_r <= coll4_r;
      x1_5_r  <= x1_4_r;
      y1_5_r  <= y1_4_r;

      out_r.lane_x.rem  <= '0;
      out_r.lane_x.num  <= {nmx_nxt, {QS{1'b0}}};
      out_r.lane_y.rem  <= '0;
      out_r.lane_y.num  <= {nmy_nxt, {QS{1'b0}}};
      out_r.den         <= {adet5_r, {(IN_FRAC_BITS+1){1'b0}}};
      out_r.side.coll   <= coll5_r;
      out_r.side.neg_x  <= nx_r[NUM_W-1];
      out_r.side.neg_y  <= ny_r[NUM_W-1];
      out_r.side.x1     <= x1_5_r;
      out_r.side.y1     <= y1_5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/cftp_div_cell.sv =====
// One restoring-division cell: one quotient bit per cycle while adv is high, for the x and y lanes.
`default_nettype none
module cftp_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire cftp_pkg::div_data_t  in_data,
  output logic                      out_valid,
  output cftp_pkg::div_data_t       out_data
);
  import cftp_pkg::*;

  logic      valid_r;
  div_data_t data_r;
  div_data_t data_nxt;

  function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           ge;
    div_lane_t      r;
    t     = {l.rem, l.num[DIVD_W-1]};
    ge    = t >= {1'b0, den};
    r.rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    r.num = {l.num[DIVD_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    data_nxt        = in_data;
    data_nxt.lane_x = div_step(in_data.lane_x, in_data.den);
    data_nxt.lane_y = div_step(in_data.lane_y, in_data.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ===== src/cftp_dist.sv =====
// Rounds and saturates the centre, then forms the squared distance for the root.
`default_nettype none
module cftp_dist (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire cftp_pkg::div_data_t  in_data,
  output logic                      out_valid,
  output cftp_pkg::sqrt_data_t      out_data
);
  import cftp_pkg::*;

  logic [5:0] v_r;

  // P1
  logic [OUT_W-1:0] cx_r, cy_r;
  logic             satc_r, big1_r, negx_r, negy_r, coll1_r;
  logic [DLIM:0]    mx_r, my_r;
  coord_t           x1_r, y1_r;
  // P2
  logic signed [DIFF2_W-1:0] ddx_r, ddy_r;
  sqrt_side_t                side2_r;
  // P3
  logic [DLIM-1:0] dx_r, dy_r;
  sqrt_side_t      side3_r;
  // P4
  logic [PP_W-1:0] hhx_r, hlx_r, llx_r, hhy_r, hly_r, lly_r;
  sqrt_side_t      side4_r;
  // P5
  logic [SQ_W-1:0] sqx_r, sqy_r;
  sqrt_side_t      side5_r;
  // P6
  sqrt_data_t      out_r;

  logic [DIVD_W:0]   sumx, sumy, gsx, gsy;
  logic [CXM_W-1:0]  cxm, cym;
  logic [DIVD_W-1:0] cgx, cgy;
  logic [OUT_W:0]    sx_nxt, sy_nxt;
  logic signed [DIFF2_W-1:0] x1s, y1s;
  logic [DIFF2_W-1:0] adx, ady;

  // returns {saturated, value}
  function automatic logic [OUT_W:0] sat_out(logic neg, logic [CXM_W-1:0] mag);
    logic             s;
    logic [OUT_W-1:0] v;
    if (neg) begin
      s = (mag[CXM_W-1:OUT_W] != '0) || (mag[OUT_W-1] && (mag[OUT_W-2:0] != '0));
      v = s ? {1'b1, {(OUT_W-1){1'b0}}} : -mag[OUT_W-1:0];
    end else begin
      s = mag[CXM_W-1:OUT_W-1] != '0;
      v = s ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
    end
    return {s, v};
  endfunction

  always_comb begin
    // centre: round the quotient from QS down to OUT_FRAC_BITS and to GUARD bits
    sumx   = {1'b0, in_data.lane_x.num} + (DIVD_W+1)'(1 << IN_FRAC_BITS);
    sumy   = {1'b0, in_data.lane_y.num} + (DIVD_W+1)'(1 << IN_FRAC_BITS);
    cxm    = sumx[DIVD_W:IN_FRAC_BITS+1];
    cym    = sumy[DIVD_W:IN_FRAC_BITS+1];
    gsx    = {1'b0, in_data.lane_x.num} + (DIVD_W+1)'(1);
    gsy    = {1'b0, in_data.lane_y.num} + (DIVD_W+1)'(1);
    cgx    = gsx[DIVD_W:1];
    cgy    = gsy[DIVD_W:1];
    sx_nxt = sat_out(in_data.side.neg_x, cxm);
    sy_nxt = sat_out(in_data.side.neg_y, cym);
    x1s    = DIFF2_W'(x1_r) <<< GUARD;
    y1s    = DIFF2_W'(y1_r) <<< GUARD;
    adx    = ddx_r[DIFF2_W-1] ? DIFF2_W'(-ddx_r) : DIFF2_W'(ddx_r);
    ady    = ddy_r[DIFF2_W-1] ? DIFF2_W'(-ddy_r) : DIFF2_W'(ddy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r    <= sx_nxt[OUT_W-1:0];
      cy_r    <= sy_nxt[OUT_W-1:0];
      satc_r  <= sx_nxt[OUT_W] | sy_nxt[OUT_W];
      big1_r  <= (cgx[DIVD_W-1:DLIM+1] != '0) || (cgy[DIVD_W-1:DLIM+1] != '0);
      mx_r    <= cgx[DLIM:0];
      my_r    <= cgy[DLIM:0];
      negx_r  <= in_data.side.neg_x;
      negy_r  <= in_data.side.neg_y;
      coll1_r <= in_data.side.coll;
      x1_r    <= in_data.side.x1;
      y1_r    <= in_data.side.y1;

      ddx_r <= negx_r ? x1s + $signed(DIFF2_W'(mx_r)) : x1s - $signed(DIFF2_W'(mx_r));
      ddy_r <= negy_r ? y1s + $signed(DIFF2_W'(my_r)) : y1s - $signed(DIFF2_W'(my_r));
      side2_r.coll  <= coll1_r;
      side2_r.sat_c <= satc_r;
      side2_r.big   <= big1_r;
      side2_r.cx    <= cx_r;
      side2_r.cy    <= cy_r;

      dx_r          <= adx[DLIM-1:0];
      dy_r          <= ady[DLIM-1:0];
      side3_r.coll  <= side2_r.coll;
      side3_r.sat_c <= side2_r.sat_c;
      side3_r.cx    <= side2_r.cx;
      side3_r.cy    <= side2_r.cy;
      // distance beyond range: radius clips
      side3_r.big   <= side2_r.big || (adx[DIFF2_W-1:DLIM] != '0) ||
                       (ady[DIFF2_W-1:DLIM] != '0);

      hhx_r   <= PP_W'(dx_r[DLIM-1:HALF_W]) * PP_W'(dx_r[DLIM-1:HALF_W]);
      hlx_r   <= PP_W'(dx_r[DLIM-1:HALF_W]) * PP_W'(dx_r[HALF_W-1:0]);
      llx_r   <= PP_W'(dx_r[HALF_W-1:0]) * PP_W'(dx_r[HALF_W-1:0]);
      hhy_r   <= PP_W'(dy_r[DLIM-1:HALF_W]) * PP_W'(dy_r[DLIM-1:HALF_W]);
      hly_r   <= PP_W'(dy_r[DLIM-1:HALF_W]) * PP_W'(dy_r[HALF_W-1:0]);
      lly_r   <= PP_W'(dy_r[HALF_W-1:0]) * PP_W'(dy_r[HALF_W-1:0]);
      side4_r <= side3_r;

      sqx_r   <= (SQ_W'(hhx_r) << (2*HALF_W)) + (SQ_W'(hlx_r) << (HALF_W+1)) + SQ_W'(llx_r);
      sqy_r   <= (SQ_W'(hhy_r) << (2*HALF_W)) + (SQ_W'(hly_r) << (HALF_W+1)) + SQ_W'(lly_r);
      side5_r <= side4_r;

      out_r.rem  <= '0;
      out_r.root <= '0;
      out_r.rad  <= RADICAND_W'(sqx_r) + RADICAND_W'(sqy_r);
      out_r.side <= side5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/cftp_sqrt_cell.sv =====
// One square-root cell: one root bit per cycle while adv is high, from two radicand bits.
`default_nettype none
module cftp_sqrt_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire cftp_pkg::sqrt_data_t  in_data,
  output logic                       out_valid,
  output cftp_pkg::sqrt_data_t       out_data
);
  import cftp_pkg::*;

  logic       valid_r;
  sqrt_data_t data_r;
  sqrt_data_t data_nxt;
  logic [SREM_W+1:0] t;
  logic [SREM_W+1:0] trial;
  logic              ge;

  always_comb begin
    t        = {in_data.rem, in_data.rad[RADICAND_W-1:RADICAND_W-2]};
    trial    = (SREM_W+2)'({in_data.root, 2'b01});
    ge       = t >= trial;
    data_nxt = in_data;
    data_nxt.rem  = ge ? SREM_W'(t - trial) : t[SREM_W-1:0];
    data_nxt.root = {in_data.root[ROOT_W-2:0], ge};
    data_nxt.rad  = {in_data.rad[RADICAND_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

// ===== src/circle_from_three_points_top.sv =====
// Top level: circle through three points, fully pipelined over a chain of cells.
// Takes three Q12.4 points per item and returns the circle centre (signed Q24.8)
// and radius (unsigned Q24.8), both rounded to nearest and clipped to 32 bits,
// with a saturated flag. When the determinant magnitude is below the threshold
// register (reset 1), or zero, the item is flagged collinear and all else is zero.
// The block accepts one item every cycle unless the output stalls it; each item passes
// in order through 6 front stages, 62 division cells (one quotient bit each, x and
// y side by side), 6 distance stages, 37 square-root cells (one root bit each) and
// the output register. A result waiting at the output stalls the pipeline only when
// the last cell holds an item. Write the threshold while idle.
`default_nettype none
module circle_from_three_points_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cftp_in_if.sink     in_ch,
  cftp_out_if.source  out_ch,
  cftp_cfg_if.sink    cfg_ch
);
  import cftp_pkg::*;

  logic             adv;
  logic [THR_W-1:0] thr_r;

  logic       div_v [DIV_CELLS+1];
  div_data_t  div_d [DIV_CELLS+1];
  logic       sq_v  [SQRT_CELLS+1];
  sqrt_data_t sq_d  [SQRT_CELLS+1];

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] cx_r, cy_r;
  logic [OUT_W-1:0]        radius_r;
  logic                    coll_r, sat_r;

  logic [ROOT_W:0]  rsum;
  logic [RAD_W-1:0] rad;
  logic             rad_sat;
  sqrt_data_t       tail;

  // advance when the last cell is empty or its item can move to the output
  assign adv = !sq_v[SQRT_CELLS] || !out_valid_r || out_ch.ready;

  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  cftp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .x1        (in_ch.first_x),
    .y1        (in_ch.first_y),
    .x2        (in_ch.second_x),
    .y2        (in_ch.second_y),
    .x3        (in_ch.third_x),
    .y3        (in_ch.third_y),
    .thr       (thr_r),
    .out_valid (div_v[0]),
    .out_data  (div_d[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    cftp_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (div_v[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  cftp_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (div_v[DIV_CELLS]),
    .in_data   (div_d[DIV_CELLS]),
    .out_valid (sq_v[0]),
    .out_data  (sq_d[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    cftp_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (sq_v[i]),
      .in_data   (sq_d[i]),
      .out_valid (sq_v[i+1]),
      .out_data  (sq_d[i+1])
    );
  end

  always_comb begin
    tail    = sq_d[SQRT_CELLS];
    // drop the extra fraction bits, ties up
    rsum    = {1'b0, tail.root} + (ROOT_W+1)'(1 << (IN_FRAC_BITS-1));
    rad     = rsum[ROOT_W:IN_FRAC_BITS];
    rad_sat = tail.side.big || (rad[RAD_W-1:OUT_W] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= sq_v[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      if (tail.side.coll) begin
        cx_r     <= '0;
        cy_r     <= '0;
        radius_r <= '0;
        coll_r   <= 1'b1;
        sat_r    <= 1'b0;
      end else begin
        cx_r     <= $signed(tail.side.cx);
        cy_r     <= $signed(tail.side.cy);
        radius_r <= rad_sat ? {OUT_W{1'b1}} : rad[OUT_W-1:0];
        coll_r   <= 1'b0;
        sat_r    <= tail.side.sat_c || rad_sat;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.center_x  = cx_r;
  assign out_ch.center_y  = cy_r;
  assign out_ch.radius    = radius_r;
  assign out_ch.collinear = coll_r;
  assign out_ch.saturated = sat_r;

endmodule
`default_nettype wire

// ===== verif/tb_circle_from_three_points_top.sv =====
// Testbench for the circumcircle block: random point triples checked against a local predictor.
`default_nettype none
module tb_circle_from_three_points_top;
  import cftp_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    collinear;
    logic                    saturated;
  } circle_t;

  class circle_scoreboard;
    circle_t     pending[$];
    logic [31:0] threshold;
    int          mismatches;

    function new();
      threshold  = 32'd1;
      mismatches = 0;
    endfunction

    static function wide_t div_round(wide_t num, wide_t den);
      wide_t mag, q;
      mag = (num < 0) ? -num : num;
      q   = (mag + (den >>> 1)) / den;
      return (num < 0) ? -q : q;
    endfunction

    static function logic [63:0] isqrt(logic [127:0] s);
      logic [63:0] r, cand;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= s) r = cand;
      end
      return r;
    endfunction

    function circle_t circumcircle(coord_t x1s, coord_t y1s, coord_t x2s, coord_t y2s,
                                   coord_t x3s, coord_t y3s);
      circle_t res;
      wide_t x1, y1, x2, y2, x3, y3, a, b, c, d, e2, f2, det, adet, nx, ny, den;
      wide_t qx, qy, cxg, cyg, dx, dy;
      logic [127:0] sumsq;
      logic [63:0] rad;
      x1 = x1s; y1 = y1s; x2 = x2s; y2 = y2s; x3 = x3s; y3 = y3s;
      a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
      e2 = a * (x1 + x2) + b * (y1 + y2);
      f2 = c * (x1 + x3) + d * (y1 + y3);
      det = b * c - a * d;
      adet = (det < 0) ? -det : det;
      res = '{default: '0};
      if (det == 0 || adet < wide_t'(threshold)) begin
        res.collinear = 1'b1;
        return res;
      end
      nx = b * f2 - d * e2;
      ny = c * e2 - a * f2;
      den = adet <<< (IN_FRAC_BITS + 1);
      if (det < 0) begin
        nx = -nx;
        ny = -ny;
      end
      qx = div_round(nx <<< OUT_FRAC_BITS, den);
      qy = div_round(ny <<< OUT_FRAC_BITS, den);
      if (qx > 64'sh7FFFFFFF) begin res.center_x = 32'h7FFFFFFF; res.saturated = 1; end
      else if (qx < -64'sh80000000) begin res.center_x = 32'h80000000; res.saturated = 1; end
      else res.center_x = qx[31:0];
      if (qy > 64'sh7FFFFFFF) begin res.center_y = 32'h7FFFFFFF; res.saturated = 1; end
      else if (qy < -64'sh80000000) begin res.center_y = 32'h80000000; res.saturated = 1; end
      else res.center_y = qy[31:0];
      // keep the centre with the input fraction bits as guard for the radius
      cxg = div_round(nx <<< GUARD, den);
      cyg = div_round(ny <<< GUARD, den);
      dx = (x1 <<< GUARD) - cxg;
      dy = (y1 <<< GUARD) - cyg;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx < (wide_t'(1) <<< DLIM) && dy < (wide_t'(1) <<< DLIM)) begin
        sumsq = dx * dx + dy * dy;
        rad = (isqrt(sumsq) + (64'd1 << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS;
      end else begin
        rad = 64'd1 << 32;
      end
      if (rad > 64'hFFFFFFFF) begin
        rad = 64'hFFFFFFFF;
        res.saturated = 1;
      end
      res.radius = rad[31:0];
      return res;
    endfunction

    function void note_triple(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                              coord_t x3, coord_t y3);
      pending.push_back(circumcircle(x1, y1, x2, y2, x3, y3));
    endfunction

    function void check_circle(circle_t got);
      circle_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result cx=%0d cy=%0d r=%0d coll=%0b sat=%0b",
                   got.center_x, got.center_y, got.radius, got.collinear, got.saturated);
        return;
      end
      want = pending.pop_front();
      if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
          got.radius !== want.radius || got.collinear !== want.collinear ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp cx=%0d cy=%0d r=%0d coll=%0b sat=%0b",
                    " got cx=%0d cy=%0d r=%0d coll=%0b sat=%0b"},
                   want.center_x, want.center_y, want.radius, want.collinear, want.saturated,
                   got.center_x, got.center_y, got.radius, got.collinear, got.saturated);
      end
    endfunction
  endclass

  logic clk, rst_n;
  cftp_in_if  in_ch();
  cftp_out_if out_ch();
  cftp_cfg_if cfg_ch();

  circle_from_three_points_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  circle_scoreboard sb = new();
  bit send_busy_free, recv_busy_free;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_gap(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic send_triple(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
                             coord_t x3, coord_t y3);
    int gap;
    gap = draw_gap(send_busy_free);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= x1; in_ch.first_y  <= y1;
    in_ch.second_x <= x2; in_ch.second_y <= y2;
    in_ch.third_x  <= x3; in_ch.third_y  <= y3;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_triple(x1, y1, x2, y2, x3, y3);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] thr);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.threshold = thr;
  endtask

  // three points on a line through a random base point, nudged off it by at most a step
  task automatic send_near_line();
    int px, py, dx, dy, k, j1, j2;
    px = $signed($urandom_range(0, 65535)) - 32768;
    py = $signed($urandom_range(0, 65535)) - 32768;
    dx = $urandom_range(0, 4000) - 2000;
    dy = $urandom_range(0, 4000) - 2000;
    k  = $urandom_range(0, 16) - 8;
    j1 = $urandom_range(0, 2) - 1;
    j2 = $urandom_range(0, 2) - 1;
    send_triple(coord_t'(px), coord_t'(py), coord_t'(px + dx), coord_t'(py + dy),
                coord_t'(px + k * dx + j1), coord_t'(py + k * dy + j2));
  endtask

  task automatic send_random(int count);
    int sel, bx, by;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) send_busy_free = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        send_triple(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      end else if (sel < 8) begin
        send_near_line();
      end else begin
        bx = $signed($urandom_range(0, 65535)) - 32768;
        by = $signed($urandom_range(0, 65535)) - 32768;
        send_triple(coord_t'(bx), coord_t'(by),
                    coord_t'(bx + $urandom_range(0, 64) - 32),
                    coord_t'(by + $urandom_range(0, 64) - 32),
                    coord_t'(bx + $urandom_range(0, 64) - 32),
                    coord_t'(by + $urandom_range(0, 64) - 32));
      end
    end
  endtask

  // result side: random stalls, with stretches of none
  initial begin
    int gap, n;
    circle_t got;
    out_ch.ready = 1'b0;
    n = 0;
    @(posedge rst_n);
    forever begin
      if (n % 80 == 0) recv_busy_free = ($urandom_range(0, 3) == 0);
      n++;
      gap = draw_gap(recv_busy_free);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.center_x  = out_ch.center_x;
      got.center_y  = out_ch.center_y;
      got.radius    = out_ch.radius;
      got.collinear = out_ch.collinear;
      got.saturated = out_ch.saturated;
      sb.check_circle(got);
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.first_x = '0; in_ch.first_y = '0; in_ch.second_x = '0;
    in_ch.second_y = '0; in_ch.third_x = '0; in_ch.third_y = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    send_busy_free = 0;
    recv_busy_free = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, degenerate and nearly degenerate triples at the reset threshold
    send_triple(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_triple(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_triple(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_triple(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_triple(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
    send_triple(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0, -16'sd1);
    send_triple(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1, 16'sd0, 16'sd0);
    send_triple(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1);
    send_triple(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd2, 16'sd1);
    send_triple(16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd16);
    send_triple(16'sd5, 16'sd7, 16'sd5, 16'sd7, 16'sd100, -16'sd3);
    send_triple(16'sd0, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
    send_triple(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd1, -16'sd32768);
    send_triple(16'sd160, 16'sd0, -16'sd160, 16'sd0, 16'sd0, 16'sd160);
    send_triple(-16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1);
    send_triple(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);

    write_threshold(32'd0);
    send_triple(16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd2);
    send_triple(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd2, 16'sd1);
    send_triple(-16'sd32768, 16'sd0, 16'sd32767, 16'sd1, 16'sd0, 16'sd0);
    send_random(380);

    write_threshold(32'hFFFFFFFF);
    send_triple(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_random(60);

    write_threshold(32'd1);
    send_random(380);

    write_threshold($urandom_range(2, 1 << 24));
    send_random(360);

    write_threshold(32'd1 << $urandom_range(8, 31));
    send_random(360);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
